>>> rtl/time_window_expiry_stream_assert.svh
// Assertion helpers for the sliding window block.
// Each expects signals named clk and rst in scope.
`ifndef TIME_WINDOW_EXPIRY_STREAM_ASSERT_SVH
`define TIME_WINDOW_EXPIRY_STREAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TWES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/twes_pkg.sv
`default_nettype none

package twes_pkg;

  localparam int unsigned CFG_DW = 30;

  // configuration register indexes
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [0:0] REG_FLUSH_AT_END  = 1'd1;

  typedef struct packed {
    logic               is_end;
    logic [15:0]        flow_tag;
    logic [15:0]        site_tag;
    logic signed [31:0] key;
    logic signed [31:0] update;
    logic [30:0]        stamp;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_stream_id;
    logic [15:0]        out_source_id;
    logic signed [31:0] out_key;
    logic signed [31:0] out_update;
    logic [31:0]        out_stamp;
    logic               is_expiry;
    logic               early_expiry;
    logic               last;
  } out_item_t;

  // one queued expiry, update already negated
  typedef struct packed {
    logic [15:0]        flow_tag;
    logic [15:0]        site_tag;
    logic signed [31:0] key;
    logic signed [31:0] update;
    logic [31:0]        expiry;
  } entry_t;

  // ST_PASS: after an early expiry the record goes out with no further due check
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PASS
  } state_t;

endpackage

`default_nettype wire

>>> rtl/twes_ram.sv
`default_nettype none

module twes_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/time_window_expiry_stream.sv
// Flow: an accepted item moves from ST_IDLE to ST_CHECK, where its first result is registered.
// Each queued expiry emitted and the pass-through go out one at a time through the
// shared 33-bit add/compare unit; no new item is accepted until the item is done,
// an end marker emits no pass-through, and result_stall holds the emission.
// Reset: control, pointers and count clear (window empty), window_length 0,
// flush_at_end 1; the expiry RAM is not cleared.
`default_nettype none

module time_window_expiry_stream #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire twes_pkg::in_item_t           item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output twes_pkg::out_item_t               result,
  input  wire logic                         cfg_write,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [twes_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned EW = $bits(twes_pkg::entry_t);

  twes_pkg::state_t    state, state_next;
  twes_pkg::in_item_t  item_q;
  logic [31:0]         exp_q;
  logic [AW-1:0]       rp, rp_next, wp, wp_next;
  logic [CW-1:0]       count, count_next;
  logic [29:0]         window_length;
  logic                flush_at_end;
  twes_pkg::entry_t    head, wentry;
  logic [EW-1:0]       head_raw;

  // shared add / compare unit
  logic [32:0] add_a, add_b, add_sum;
  logic        add_sub;
  logic        due;

  logic can_emit, empty, full;
  logic do_pop, do_pass, do_clear, pop_early, pop_last;
  logic pop_fire, pass_fire;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= '0;
      flush_at_end  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        twes_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
        twes_pkg::REG_FLUSH_AT_END:  flush_at_end  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- shared unit ----------------
  // idle: stamp + window_length for the incoming beat
  // check: head.expiry - stamp, borrow means the head is due
  always_comb begin
    if (state == twes_pkg::ST_IDLE) begin
      add_a   = {3'b0, window_length};
      add_b   = {2'b0, item.stamp};
      add_sub = 1'b0;
    end else begin
      add_a   = {1'b0, head.expiry};
      add_b   = {2'b0, item_q.stamp};
      add_sub = 1'b1;
    end
    add_sum = add_a + (add_b ^ {33{add_sub}}) + {32'b0, add_sub};
  end

  assign due = add_sum[32];

  // ---------------- decisions ----------------
  assign can_emit = !result_valid || !result_stall;
  assign empty    = (count == '0);
  assign full     = (count == CW'(WINDOW_DEPTH));

  always_comb begin
    do_pop    = 1'b0;
    do_pass   = 1'b0;
    do_clear  = 1'b0;
    pop_early = 1'b0;
    pop_last  = 1'b0;
    if (state == twes_pkg::ST_CHECK) begin
      if (item_q.is_end) begin
        if (flush_at_end && !empty) begin
          do_pop   = 1'b1;
          pop_last = (count == CW'(1));
        end else begin
          do_clear = 1'b1;
        end
      end else if (!empty && due) begin
        do_pop = 1'b1;
      end else if (full) begin
        do_pop    = 1'b1;
        pop_early = 1'b1;
      end else begin
        do_pass = 1'b1;
      end
    end else if (state == twes_pkg::ST_PASS) begin
      do_pass = 1'b1;
    end
  end

  assign pop_fire  = do_pop && can_emit;
  assign pass_fire = do_pass && can_emit;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      twes_pkg::ST_IDLE:  if (item_valid) state_next = twes_pkg::ST_CHECK;
      twes_pkg::ST_CHECK: begin
        if (pass_fire || do_clear) state_next = twes_pkg::ST_IDLE;
        else if (pop_fire && pop_early) state_next = twes_pkg::ST_PASS;
      end
      twes_pkg::ST_PASS:  if (pass_fire) state_next = twes_pkg::ST_IDLE;
      default:            state_next = twes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != twes_pkg::ST_IDLE);
    rp_next    = rp;
    wp_next    = wp;
    count_next = count;
    if (do_clear) begin
      rp_next    = '0;
      wp_next    = '0;
      count_next = '0;
    end else if (pop_fire) begin
      rp_next    = (rp == AW'(WINDOW_DEPTH - 1)) ? '0 : rp + 1'b1;
      count_next = count - 1'b1;
    end else if (pass_fire) begin
      wp_next    = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twes_pkg::ST_IDLE;
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      rp    <= rp_next;
      wp    <= wp_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == twes_pkg::ST_IDLE && item_valid) begin
      item_q <= item;
      exp_q  <= add_sum[31:0];
    end
  end

  // ---------------- expiry storage ----------------
  always_comb begin
    wentry.flow_tag = item_q.flow_tag;
    wentry.site_tag = item_q.site_tag;
    wentry.key      = item_q.key;
    wentry.update   = ~item_q.update + 32'sd1;
    wentry.expiry   = exp_q;
  end

  // read address follows rp_next so the head is current in the cycle after a pop
  twes_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .we    (pass_fire),
    .waddr (wp),
    .wdata (wentry),
    .raddr (rp_next),
    .rdata (head_raw)
  );

  assign head = twes_pkg::entry_t'(head_raw);

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop_fire || pass_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      result.out_stream_id <= head.flow_tag;
      result.out_source_id <= head.site_tag;
      result.out_key       <= head.key;
      result.out_update    <= head.update;
      result.out_stamp     <= head.expiry;
      result.is_expiry     <= 1'b1;
      result.early_expiry  <= pop_early;
      result.last          <= pop_last;
    end else if (pass_fire) begin
      result.out_stream_id <= item_q.flow_tag;
      result.out_source_id <= item_q.site_tag;
      result.out_key       <= item_q.key;
      result.out_update    <= item_q.update;
      result.out_stamp     <= {1'b0, item_q.stamp};
      result.is_expiry     <= 1'b0;
      result.early_expiry  <= 1'b0;
      result.last          <= 1'b1;
    end
  end

  // ---------------- assertions ----------------
  `include "time_window_expiry_stream_assert.svh"

  `TWES_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(WINDOW_DEPTH), "entry count over depth")
  `TWES_ASSERT_NOW(a_pop_nonempty, pop_fire, count != '0, "expiry emitted from empty window")
  `TWES_ASSERT_NEXT(a_pass_push, pass_fire, count == $past(count) + 1'b1, "push lost on pass beat")
  `TWES_ASSERT_NEXT(a_accept_check, item_valid && !item_stall, state == twes_pkg::ST_CHECK,
    "accepted beat not processed")
  `TWES_ASSERT_NEXT(a_early_full, pop_fire && pop_early, count == CW'(WINDOW_DEPTH - 1),
    "early expiry while window not full")

endmodule

`default_nettype wire
